>>> rtl/core/rptw_pkg.sv
// ============================================================================
// rptw_pkg: shared definitions of the radix page table walker
// Field widths, request codes, register addresses and the result bundle.
// ============================================================================
`default_nettype none

package rptw_pkg;

    // Request and result field widths.
    localparam int ACT_W   = 2;
    localparam int VP_W    = 45;
    localparam int PPN_W   = 52;
    localparam int ENTRY_W = PPN_W + 1;

    // Configuration register widths and reset values.
    localparam int ROOT_W  = 6;
    localparam int FFREE_W = 7;
    localparam logic [ROOT_W-1:0]  ROOT_RST  = 6'd0;
    localparam logic [FFREE_W-1:0] FFREE_RST = 7'd1;

    // APB register file.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ROOT_FRAME = 1'b0;
    localparam logic REG_FIRST_FREE = 1'b1;

    // Request actions. The unused code behaves as a query.
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MAP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNMAP = 2'd2;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_FRAMES = 1'b1;

    // Completed walk handed from the sequencer to the output register.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [PPN_W-1:0] ppn;
        logic             status;
    } rptw_result_t;

endpackage

`default_nettype wire

>>> rtl/core/rptw_ram.sv
// ============================================================================
// rptw_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ============================================================================
`default_nettype none

module rptw_ram #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/rptw_mod.sv
// ============================================================================
// rptw_mod: frame number reduction unit
// Reduces pointers modulo FRAMES, eight bits per cycle (a mask if a power of 2).
// ============================================================================
`default_nettype none

module rptw_mod import rptw_pkg::*; #(
    parameter int FRAMES = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [PPN_W-1:0]          operand,
    output logic                           done,
    output logic [$clog2(FRAMES)-1:0]      result
);

    localparam int FRAME_W = $clog2(FRAMES);
    localparam bit IS_POW2 = (FRAMES & (FRAMES - 1)) == 0;
    localparam int STEP    = 8;
    localparam int ROUNDS  = (PPN_W + STEP - 1) / STEP;
    localparam int PAD_W   = ROUNDS * STEP;
    localparam int CNT_W   = $clog2(ROUNDS + 1);
    localparam logic [FRAME_W:0] FRAMES_C = (FRAME_W + 1)'(FRAMES);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PAD_W-1:0]   shift_reg;
    logic [FRAME_W-1:0] rem_reg;
    logic [FRAME_W-1:0] rem_next;

    // Restoring reduction of the next eight operand bits, most significant first.
    always_comb
    begin
        logic [FRAME_W:0]   wide;
        logic [FRAME_W-1:0] part;
        part = rem_reg;
        for (int i = 0; i < STEP; i++)
        begin
            wide = {part, shift_reg[PAD_W-1-i]};
            if (wide >= FRAMES_C)
            begin
                wide = wide - FRAMES_C;
            end
            part = wide[FRAME_W-1:0];
        end
        rem_next = part;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            if (IS_POW2)
            begin
                rem_reg  <= operand[FRAME_W-1:0];
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                shift_reg <= PAD_W'(operand);
                rem_reg   <= '0;
                cnt_reg   <= CNT_W'(ROUNDS);
                busy_reg  <= 1'b1;
                done_reg  <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << STEP;
            cnt_reg   <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/rptw_ctrl.sv
// ============================================================================
// rptw_ctrl: walk sequencer
// Steps one request through the table levels over the single store port.
// ============================================================================
`default_nettype none

module rptw_ctrl import rptw_pkg::*; #(
    parameter int LEVELS     = 5,
    parameter int INDEX_BITS = 9,
    parameter int FRAMES     = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_stall,
    input  wire logic [ACT_W-1:0]                        action,
    input  wire logic [VP_W-1:0]                         virtual_page,
    input  wire logic [PPN_W-1:0]                        new_ppn,
    input  wire logic [ROOT_W-1:0]                       root_frame,
    input  wire logic                                    ff_we,
    input  wire logic [FFREE_W-1:0]                      ff_value,
    input  wire logic                                    rsp_free,
    output rptw_result_t                                 done,
    output logic                                         mem_we,
    output logic [$clog2(FRAMES)+INDEX_BITS-1:0]         mem_addr,
    output logic [ENTRY_W-1:0]                           mem_wdata,
    input  wire logic [ENTRY_W-1:0]                      mem_rdata,
    output logic                                         mod_start,
    output logic [PPN_W-1:0]                             mod_operand,
    input  wire logic                                    mod_done,
    input  wire logic [$clog2(FRAMES)-1:0]               mod_result
);

    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int ADDR_W    = FRAME_W + INDEX_BITS;
    localparam int DEPTH     = FRAMES * (1 << INDEX_BITS);
    localparam int WALK_BITS = LEVELS * INDEX_BITS;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NF_W      = ($clog2(FRAMES + 1) > FFREE_W) ? $clog2(FRAMES + 1) : FFREE_W;
    localparam logic [LVL_W-1:0]  LAST_LVL   = LVL_W'(LEVELS - 1);
    localparam logic [NF_W-1:0]   FRAMES_NF  = NF_W'(FRAMES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_WAIT,
        ST_READ,
        ST_DATA,
        ST_ZERO,
        ST_LINK,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [LVL_W-1:0]       level_reg;
    logic [ACT_W-1:0]       act_reg;
    logic [WALK_BITS-1:0]   vp_reg;
    logic [PPN_W-1:0]       ppn_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [PPN_W-1:0]       leaf_reg;
    logic                   reached_reg;
    logic                   status_reg;
    logic [FRAME_W-1:0]     nf_reg;
    logic [ADDR_W-1:0]      cnt_reg;
    logic [NF_W-1:0]        next_frame_reg;

    logic [WALK_BITS+VP_W-1:0] vp_ext;
    logic [INDEX_BITS-1:0]     level_index;
    logic                      accept;
    logic                      last_level;
    logic                      is_map;
    logic                      is_unmap;
    logic                      is_query;
    logic                      entry_valid;

    assign vp_ext      = (WALK_BITS + VP_W)'(virtual_page);
    assign level_index = vp_reg[WALK_BITS-1 -: INDEX_BITS];
    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && (state_reg == ST_IDLE);
    assign last_level  = (level_reg == LAST_LVL);
    assign is_map      = (act_reg == ACT_MAP);
    assign is_unmap    = (act_reg == ACT_UNMAP);
    assign is_query    = !is_map && !is_unmap;
    assign entry_valid = mem_rdata[0];

    // Store port and reduction unit requests.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_addr    = {frame_reg, level_index};
        mem_wdata   = '0;
        mod_start   = 1'b0;
        mod_operand = PPN_W'(root_frame);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = cnt_reg;
            end
            ST_IDLE:
            begin
                mod_start = accept;
            end
            ST_DATA:
            begin
                mod_start   = entry_valid && !last_level;
                mod_operand = mem_rdata[ENTRY_W-1:1];
            end
            ST_ZERO:
            begin
                mem_we   = 1'b1;
                mem_addr = {nf_reg, cnt_reg[INDEX_BITS-1:0]};
            end
            ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_addr  = addr_reg;
                mem_wdata = {(PPN_W - FRAME_W)'(0), nf_reg, 1'b1};
            end
            ST_FINISH:
            begin
                mem_we    = rsp_free && reached_reg && (is_map || is_unmap);
                mem_addr  = addr_reg;
                mem_wdata = is_map ? {ppn_reg, 1'b1} : '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        done.valid  = (state_reg == ST_FINISH) && rsp_free;
        done.found  = is_query && reached_reg;
        done.ppn    = (is_query && reached_reg) ? leaf_reg : '0;
        done.status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            level_reg      <= '0;
            next_frame_reg <= NF_W'(FFREE_RST);
        end
        else
        begin
            if (ff_we)
            begin
                next_frame_reg <= NF_W'(ff_value);
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg     <= action;
                        vp_reg      <= vp_ext[WALK_BITS-1:0];
                        ppn_reg     <= new_ppn;
                        level_reg   <= '0;
                        reached_reg <= 1'b1;
                        status_reg  <= STATUS_OK;
                        leaf_reg    <= '0;
                        state_reg   <= ST_MOD_WAIT;
                    end
                end
                ST_MOD_WAIT:
                begin
                    if (mod_done)
                    begin
                        frame_reg <= mod_result;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    addr_reg  <= mem_addr;
                    state_reg <= ST_DATA;
                end
                ST_DATA:
                begin
                    if (entry_valid)
                    begin
                        leaf_reg <= mem_rdata[ENTRY_W-1:1];
                        if (last_level)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            level_reg <= level_reg + 1'b1;
                            vp_reg    <= vp_reg << INDEX_BITS;
                            state_reg <= ST_MOD_WAIT;
                        end
                    end
                    else if (is_map)
                    begin
                        if (last_level)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else if (next_frame_reg >= FRAMES_NF)
                        begin
                            status_reg  <= STATUS_NO_FRAMES;
                            reached_reg <= 1'b0;
                            state_reg   <= ST_FINISH;
                        end
                        else
                        begin
                            nf_reg         <= next_frame_reg[FRAME_W-1:0];
                            next_frame_reg <= next_frame_reg + 1'b1;
                            cnt_reg        <= '0;
                            state_reg      <= ST_ZERO;
                        end
                    end
                    else
                    begin
                        reached_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                end
                ST_ZERO:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg[INDEX_BITS-1:0])
                    begin
                        state_reg <= ST_LINK;
                    end
                end
                ST_LINK:
                begin
                    frame_reg <= nf_reg;
                    level_reg <= level_reg + 1'b1;
                    vp_reg    <= vp_reg << INDEX_BITS;
                    state_reg <= ST_READ;
                end
                ST_FINISH:
                begin
                    if (rsp_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The allocator only moves forward unless it is reloaded by a register write.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ff_we |=> next_frame_reg >= $past(next_frame_reg))
        else $error("next free frame moved backward");

    // The store is never written while waiting for a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("store written while idle");

    // Only a map can run out of frames, and a map never reports a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done.valid && done.status) |-> (is_map && !done.found))
        else $error("frame exhaustion reported outside a map");

    // A frame is linked into the table only right after its clearing sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> ($past(state_reg) == ST_ZERO))
        else $error("frame linked without being cleared");

endmodule

`default_nettype wire

>>> rtl/core/radix_page_table_walker.sv
// ============================================================================
// radix_page_table_walker: multi-level radix page table walker
// Query, map and unmap of virtual pages in an on-chip frame store.
// ============================================================================
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------
//  req       in         req_valid / req_stall  action, virtual_page, new_ppn
//  rsp       out        rsp_valid / rsp_stall  found, ppn_out, status
//  apb       in         psel, penable, pready  paddr, pwrite, pwdata, prdata
//
//  A request walks the table one level at a time through the single store
//  port: per level, the frame reduction, then a read state and a data state.
//  Every frame a map allocates adds a clearing sweep of its 2**INDEX_BITS
//  entries plus a link write, which takes the place of the reduction step.
//  With a FRAMES that is not a power of two, each reduction is an iterative
//  pass through the reduction unit, eight operand bits at a time.
//  After reset the whole store of FRAMES * 2**INDEX_BITS entries (32768 by
//  default) is cleared; requests are held off meanwhile, register writes work.
//  A finished response waits in the output register; the next request is
//  taken meanwhile, and only the end of its walk waits on rsp_stall.
//
`default_nettype none

module radix_page_table_walker import rptw_pkg::*; #(
    parameter int LEVELS     = 5,
    parameter int INDEX_BITS = 9,
    parameter int FRAMES     = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Request channel.
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [VP_W-1:0]   virtual_page,
    input  wire logic [PPN_W-1:0]  new_ppn,
    // Response channel.
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic                   found,
    output logic [PPN_W-1:0]       ppn_out,
    output logic                   status,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int ADDR_W  = FRAME_W + INDEX_BITS;
    localparam int DEPTH   = FRAMES * (1 << INDEX_BITS);

    // Config registers; user writes only while the walker is idle (unchecked).
    logic [ROOT_W-1:0]  root_frame_reg;
    logic [FFREE_W-1:0] first_free_reg;
    logic               cfg_write;
    logic               ff_we;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign ff_we     = cfg_write && (paddr[2] == REG_FIRST_FREE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= ROOT_RST;
            first_free_reg <= FFREE_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROOT_FRAME)
            begin
                root_frame_reg <= pwdata[ROOT_W-1:0];
            end
            else
            begin
                first_free_reg <= pwdata[FFREE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FIRST_FREE) ? APB_DW'(first_free_reg)
                                                 : APB_DW'(root_frame_reg);

    // Sequencer, shared reduction unit and frame store.
    rptw_result_t          done;
    logic                  rsp_free;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ENTRY_W-1:0]    mem_rdata;
    logic                  mod_start;
    logic [PPN_W-1:0]      mod_operand;
    logic                  mod_done;
    logic [FRAME_W-1:0]    mod_result;

    rptw_ctrl #(
        .LEVELS     (LEVELS),
        .INDEX_BITS (INDEX_BITS),
        .FRAMES     (FRAMES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .virtual_page (virtual_page),
        .new_ppn      (new_ppn),
        .root_frame   (root_frame_reg),
        .ff_we        (ff_we),
        .ff_value     (pwdata[FFREE_W-1:0]),
        .rsp_free     (rsp_free),
        .done         (done),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .mod_start    (mod_start),
        .mod_operand  (mod_operand),
        .mod_done     (mod_done),
        .mod_result   (mod_result)
    );

    // The root and every stored frame pointer are reduced modulo FRAMES here.
    rptw_mod #(
        .FRAMES (FRAMES)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .operand (mod_operand),
        .done    (mod_done),
        .result  (mod_result)
    );

    // Entry layout: bit 0 valid, upper bits a frame number or a physical page.
    rptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Output register: holds one response until the receiver takes it.
    logic               rsp_valid_reg;
    logic               found_reg;
    logic [PPN_W-1:0]   ppn_out_reg;
    logic               status_reg;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done.valid)
        begin
            rsp_valid_reg <= 1'b1;
            found_reg     <= done.found;
            ppn_out_reg   <= done.ppn;
            status_reg    <= done.status;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign found     = found_reg;
    assign ppn_out   = ppn_out_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench of the radix page table walker
// Queries, maps and unmaps go in through the request channel while a shadow
// copy of the frame store predicts every response. Register writes move the
// root table and rewind the frame allocator between phases.
// ============================================================================

module testbench;

    import rptw_pkg::*;

    // Geometry of the instance under test (the block's defaults).
    localparam int WALK_LEVELS = 5;
    localparam int IDX_BITS    = 9;
    localparam int NUM_FRAMES  = 64;
    localparam int FRAME_SLOTS = 1 << IDX_BITS;

    // The fourth action code is not named by the package; the block treats it
    // as a query, so the bench gives it a name of its own.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [VP_W-1:0]  VP_ALL  = '1;
    localparam logic [PPN_W-1:0] PPN_ALL = '1;

    // Random phases: one register setting and one idling mode per phase.
    localparam int NUM_PHASES       = 6;
    localparam int PHASE_REQUESTS   = 200;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT   = 150000;
    localparam int TAIL_CYCLES      = 60;
    localparam int PHASE_ROOT[NUM_PHASES]  = '{0, 63, 21, 63, 0, 40};
    localparam int PHASE_FFREE[NUM_PHASES] = '{1, 0, 30, 64, 60, 2};

    typedef struct packed {
        logic             found;
        logic [PPN_W-1:0] ppn;
        logic             status;
    } walk_rsp_t;

    // ------------------------------------------------------------------------
    // Shadow page table: mirrors the frame store and the allocator, predicts
    // the response of every accepted request and checks the block's output.
    // ------------------------------------------------------------------------
    class page_table_scoreboard;
        bit [ENTRY_W-1:0] shadow_slots [NUM_FRAMES*FRAME_SLOTS];
        int unsigned      root_frame;
        int unsigned      next_free;
        walk_rsp_t        expected_walks[$];
        int unsigned      errors;
        int unsigned      per_action[4];
        int unsigned      hits;
        int unsigned      out_of_frames;
        int unsigned      allocations;

        function new();
            root_frame = ROOT_RST;
            next_free  = FFREE_RST;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void configure(logic reg_idx, logic [APB_DW-1:0] value);
            if (reg_idx == REG_ROOT_FRAME)
                root_frame = value[ROOT_W-1:0];
            else
                next_free = value[FFREE_W-1:0];
        endfunction

        // Walk the shadow table exactly as the block does and queue the result.
        function void note_request(logic [ACT_W-1:0] act, logic [VP_W-1:0] vp,
                                   logic [PPN_W-1:0] ppn);
            int unsigned      frame;
            int unsigned      slot;
            int unsigned      idx;
            int unsigned      fresh;
            bit [ENTRY_W-1:0] entry;
            bit               reached;
            walk_rsp_t        rsp;

            frame   = root_frame % NUM_FRAMES;
            slot    = 0;
            entry   = '0;
            reached = 1'b1;
            rsp     = '0;
            per_action[act]++;

            for (int lvl = 0; lvl < WALK_LEVELS; lvl++) begin
                idx   = 32'((vp >> (IDX_BITS * (WALK_LEVELS - 1 - lvl)))
                            & (FRAME_SLOTS - 1));
                slot  = (frame % NUM_FRAMES) * FRAME_SLOTS + idx;
                entry = shadow_slots[slot];
                if (!entry[0]) begin
                    if (act == ACT_MAP) begin
                        // A missing leaf is simply written below.
                        if (lvl == WALK_LEVELS - 1)
                            break;
                        if (next_free >= NUM_FRAMES) begin
                            rsp.status = STATUS_NO_FRAMES;
                            reached    = 1'b0;
                            break;
                        end
                        fresh = next_free;
                        next_free++;
                        allocations++;
                        // The new frame is wiped before the pointer goes in,
                        // even when it is the very frame being walked.
                        for (int s = 0; s < FRAME_SLOTS; s++)
                            shadow_slots[fresh * FRAME_SLOTS + s] = '0;
                        entry = {PPN_W'(fresh), 1'b1};
                        shadow_slots[slot] = entry;
                    end else begin
                        reached = 1'b0;
                        break;
                    end
                end
                if (lvl + 1 < WALK_LEVELS)
                    frame = int'(entry[ENTRY_W-1:1] % NUM_FRAMES);
            end

            case (act)
                ACT_MAP: begin
                    if (reached)
                        shadow_slots[slot] = {ppn, 1'b1};
                end
                ACT_UNMAP: begin
                    if (reached)
                        shadow_slots[slot] = '0;
                end
                default: begin
                    if (reached && entry[0]) begin
                        rsp.found = 1'b1;
                        rsp.ppn   = entry[ENTRY_W-1:1];
                    end
                end
            endcase

            if (rsp.found)
                hits++;
            if (rsp.status == STATUS_NO_FRAMES)
                out_of_frames++;
            expected_walks.push_back(rsp);
        endfunction

        function void check_response(logic f, logic [PPN_W-1:0] p, logic s);
            walk_rsp_t exp_rsp;

            if (expected_walks.size() == 0) begin
                report("response arrived with no request outstanding");
                return;
            end
            exp_rsp = expected_walks.pop_front();
            if (f !== exp_rsp.found)
                report($sformatf("found %b, expected %b", f, exp_rsp.found));
            if (p !== exp_rsp.ppn)
                report($sformatf("ppn_out %h, expected %h", p, exp_rsp.ppn));
            if (s !== exp_rsp.status)
                report($sformatf("status %b, expected %b", s, exp_rsp.status));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    logic [ACT_W-1:0]  action       = ACT_QUERY;
    logic [VP_W-1:0]   virtual_page = '0;
    logic [PPN_W-1:0]  new_ppn      = '0;
    logic              rsp_valid;
    logic              rsp_stall    = 1'b0;
    logic              found;
    logic [PPN_W-1:0]  ppn_out;
    logic              status;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Idling knobs, in percent of cycles, changed by the main sequence.
    int  send_idle_pct  = 0;
    int  rsp_idle_pct   = 0;
    // Long response hold-off used to back the block up into its input.
    logic pressure_start = 1'b0;
    logic hold_off       = 1'b0;

    // Virtual pages that have been mapped on purpose; reused so most traffic
    // walks deep into existing paths instead of missing at the top level.
    logic [VP_W-1:0] mapped_pages[$];

    int unsigned quiet_cycles = 0;

    page_table_scoreboard walks = new();

    radix_page_table_walker #(
        .LEVELS     (WALK_LEVELS),
        .INDEX_BITS (IDX_BITS),
        .FRAMES     (NUM_FRAMES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .virtual_page (virtual_page),
        .new_ppn      (new_ppn),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .found        (found),
        .ppn_out      (ppn_out),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Monitor: both handshakes are sampled at the rising edge, where the
    // driven inputs have been stable since the falling edge before it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                walks.note_request(action, virtual_page, new_ppn);
            if (rsp_valid && !rsp_stall)
                walks.check_response(found, ppn_out, status);
        end
    end

    // Watchdog: counts cycles in which no handshake of any kind completes.
    // The limit covers the store clear after reset, the
    // response hold-off and a map that allocates four frames, several times.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, walks.expected_walks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Response side: random stalls plus the long hold-off when it is active.
    always @(negedge clk)
    begin
        rsp_stall <= hold_off || ($urandom_range(99) < rsp_idle_pct);
    end

    // The hold-off is timed here, apart from the request sequence, so that
    // the sender keeps offering requests while the block backs up.
    initial
    begin
        wait (pressure_start);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one request after a random number of idle cycles and hold it until
    // it is taken. Starts and ends at a falling edge.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [VP_W-1:0] vp,
                                input logic [PPN_W-1:0] ppn);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        action       <= act;
        virtual_page <= vp;
        new_ppn      <= ppn;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted response has come back.
    // Each request yields exactly one response, so the block is idle then.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (walks.expected_walks.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // APB write in setup and access cycles, then a read back of the register.
    // Ends at a falling edge after the read, with psel low again.
    task automatic write_register(input logic reg_idx, input logic [APB_DW-1:0] value,
                                  input int width);
        logic [APB_DW-1:0] mask;

        mask    = (APB_DW'(1) << width) - 1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        walks.configure(reg_idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
            walks.report($sformatf("register %0d reads %h, written %h",
                                   reg_idx, prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, then point the walker at a root table and rewind the allocator.
    task automatic drain_and_configure(input int root, input int first_free);
        wait_for_results();
        write_register(REG_ROOT_FRAME, APB_DW'(root), ROOT_W);
        write_register(REG_FIRST_FREE, APB_DW'(first_free), FFREE_W);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [ACT_W-1:0] act;
        logic [VP_W-1:0]  vp;
        logic [PPN_W-1:0] ppn;
        int               pick;
        int               lvl;
        int               shape;
        bit               fresh;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling. Registers are written during the store
        // clear; requests wait on req_stall until the clear is done.
        drain_and_configure(0, 1);

        // Empty table: a query and an unmap both miss at the top level.
        send_request(ACT_QUERY, '0, '0);
        send_request(ACT_UNMAP, '0, PPN_ALL);
        // First map builds the whole path; the leaf holds the largest page.
        send_request(ACT_MAP, '0, PPN_ALL);
        send_request(ACT_QUERY, '0, '0);
        // The top page number shares no inner table with page zero.
        send_request(ACT_MAP, VP_ALL, '0);
        // The spare action code reads like a query.
        send_request(ACT_SPARE, VP_ALL, PPN_ALL);
        // Overwrite an existing leaf.
        send_request(ACT_MAP, '0, 52'h5_5555_5555_5555);
        send_request(ACT_QUERY, '0, '0);
        // Neighbour page: the path exists but its leaf is empty.
        send_request(ACT_QUERY, 45'h1, '0);
        send_request(ACT_UNMAP, 45'h1, '0);
        send_request(ACT_UNMAP, '0, '0);
        send_request(ACT_QUERY, '0, '0);

        // Only two frames left: a map on a fresh path keeps the two inner
        // levels it got and then reports that frames ran out.
        drain_and_configure(0, 62);
        send_request(ACT_MAP, 45'h1555_5555_5555, 52'hA_AAAA_AAAA_AAAA);
        send_request(ACT_QUERY, 45'h1555_5555_5555, '0);
        send_request(ACT_MAP, 45'h1555_5555_5000, 52'h1);

        // Allocator exhausted: old paths still map, a new path runs out.
        drain_and_configure(0, 64);
        send_request(ACT_MAP, VP_ALL, 52'hA_AAAA_AAAA_AAAA);
        send_request(ACT_QUERY, VP_ALL, '0);
        send_request(ACT_MAP, 45'h2, 52'h8_0000_0000_0001);
        send_request(ACT_QUERY, 45'h2, '0);
        send_request(ACT_MAP, 45'h0_1000_0000_0000, 52'h3);
        send_request(ACT_QUERY, 45'h0_1000_0000_0000, '0);

        mapped_pages.push_back('0);
        mapped_pages.push_back(VP_ALL);
        mapped_pages.push_back(45'h2);

        // Random phases. The idling mode moves from a slow receiver to a slow
        // sender and finally to none; the last mode starts with the long
        // receiver hold-off.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_and_configure(PHASE_ROOT[phase], PHASE_FFREE[phase]);
            if (phase < 2) begin
                send_idle_pct = 7;
                rsp_idle_pct  = 45;
            end else if (phase < 4) begin
                send_idle_pct = 45;
                rsp_idle_pct  = 7;
            end else begin
                send_idle_pct = 0;
                rsp_idle_pct  = 0;
            end
            if (phase == 4)
                pressure_start = 1'b1;

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                pick = $urandom_range(99);
                if (pick < 38)
                    act = ACT_QUERY;
                else if (pick < 72)
                    act = ACT_MAP;
                else if (pick < 93)
                    act = ACT_UNMAP;
                else
                    act = ACT_SPARE;

                // Mostly known pages, often with a new leaf index or one
                // level's index changed; a quarter are fully random pages.
                shape = $urandom_range(99);
                fresh = (shape < 25);
                if (fresh) begin
                    vp = VP_W'({$urandom, $urandom});
                end else begin
                    vp = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
                    if (shape < 55) begin
                        vp[IDX_BITS-1:0] = IDX_BITS'($urandom);
                    end else if (shape < 65) begin
                        lvl = $urandom_range(WALK_LEVELS - 1);
                        vp[lvl*IDX_BITS +: IDX_BITS] = IDX_BITS'($urandom);
                    end
                end

                pick = $urandom_range(99);
                if (pick < 8)
                    ppn = PPN_ALL;
                else if (pick < 12)
                    ppn = '0;
                else
                    ppn = PPN_W'({$urandom, $urandom});

                if (act == ACT_MAP && fresh) begin
                    if (mapped_pages.size() < 48)
                        mapped_pages.push_back(vp);
                    else
                        mapped_pages[$urandom_range(47)] = vp;
                end

                send_request(act, vp, ppn);
            end
        end

        // Let any stray response show up before the verdict.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d queries (%0d hits), %0d maps, %0d unmaps, %0d spare-code requests",
                 walks.per_action[ACT_QUERY], walks.hits, walks.per_action[ACT_MAP],
                 walks.per_action[ACT_UNMAP], walks.per_action[ACT_SPARE]);
        $display("%0d frames allocated, %0d maps out of frames, %0d register settings",
                 walks.allocations, walks.out_of_frames, NUM_PHASES + 3);
        if (walks.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rptw_pkg.sv
rtl/core/rptw_ram.sv
rtl/core/rptw_mod.sv
rtl/core/rptw_ctrl.sv
rtl/core/radix_page_table_walker.sv
verif/testbench.sv
